// ===== rtl/srd_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Shared types and constants for the silence run detector.
// No dependencies; every other file in rtl/ refers to this package.

package srd_pkg;

  // Default sizes handed to the top-level parameters.
  localparam int FRAME_BITS_DEF  = 32;
  localparam int SAMPLE_BITS_DEF = 24;

  // Fixed widths of the configuration registers and the result fields.
  localparam int THR_W   = 24;
  localparam int MINF_W  = 24;
  localparam int REG_W   = 32;
  localparam int ADDR_W  = 4;
  localparam int OUT_W   = 32;
  localparam int OUT_TDATA_W = 2 * OUT_W;

  typedef enum logic [1:0] {
    REG_THRESHOLD    = 2'd0,
    REG_MIN_FRAMES   = 2'd1,
    REG_TRIM_MODE    = 2'd2,
    REG_REGION_START = 2'd3
  } reg_idx_t;

  typedef struct packed {
    logic [THR_W-1:0]  threshold;
    logic [MINF_W-1:0] min_frames;
    logic              trim_mode;
    logic [OUT_W-1:0]  region_start;
  } cfg_t;

  typedef struct packed {
    logic frame_end;
    logic region_end;
  } flags_t;

endpackage

`default_nettype wire

// ===== rtl/srd_cfg_regs.sv =====
`timescale 1ns / 1ps
`default_nettype none
// APB-style register file for the silence run detector settings.
// Depends on srd_pkg for the register map and the settings struct.

module srd_cfg_regs (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       cfg_psel,
  input  wire logic                       cfg_penable,
  input  wire logic                       cfg_pwrite,
  input  wire logic [srd_pkg::ADDR_W-1:0] cfg_paddr,
  input  wire logic [srd_pkg::REG_W-1:0]  cfg_pwdata,
  output logic      [srd_pkg::REG_W-1:0]  cfg_prdata,
  output logic                            cfg_pready,
  output srd_pkg::cfg_t                   cfg
);

  srd_pkg::cfg_t     cfg_r;
  srd_pkg::cfg_t     cfg_nxt;
  srd_pkg::reg_idx_t idx;
  logic              wr_en;

  assign idx        = srd_pkg::reg_idx_t'(cfg_paddr[srd_pkg::ADDR_W-1:2]);
  assign cfg_pready = 1'b1;
  assign wr_en      = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign cfg        = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      unique case (idx)
        srd_pkg::REG_THRESHOLD:    cfg_nxt.threshold    = cfg_pwdata[srd_pkg::THR_W-1:0];
        srd_pkg::REG_MIN_FRAMES:   cfg_nxt.min_frames   = cfg_pwdata[srd_pkg::MINF_W-1:0];
        srd_pkg::REG_TRIM_MODE:    cfg_nxt.trim_mode    = cfg_pwdata[0];
        srd_pkg::REG_REGION_START: cfg_nxt.region_start = cfg_pwdata[srd_pkg::OUT_W-1:0];
        default:                   cfg_nxt = cfg_r;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      srd_pkg::REG_THRESHOLD:    cfg_prdata = srd_pkg::REG_W'(cfg_r.threshold);
      srd_pkg::REG_MIN_FRAMES:   cfg_prdata = srd_pkg::REG_W'(cfg_r.min_frames);
      srd_pkg::REG_TRIM_MODE:    cfg_prdata = srd_pkg::REG_W'(cfg_r.trim_mode);
      srd_pkg::REG_REGION_START: cfg_prdata = srd_pkg::REG_W'(cfg_r.region_start);
      default:                   cfg_prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.threshold    <= '0;
      cfg_r.min_frames   <= srd_pkg::MINF_W'(1);
      cfg_r.trim_mode    <= 1'b0;
      cfg_r.region_start <= '0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/srd_mag_stage.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Input register stage: takes one sample word and holds its magnitude and flags.
// Depends on srd_pkg for the flag struct.

module srd_mag_stage #(
  parameter int SAMPLE_BITS = srd_pkg::SAMPLE_BITS_DEF
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   in_tvalid,
  output logic                        in_tready,
  input  wire logic [SAMPLE_BITS-1:0] in_sample,
  input  srd_pkg::flags_t             in_flags,
  input  wire logic                   advance,
  output logic                        s1_valid,
  output logic      [SAMPLE_BITS-1:0] s1_mag,
  output srd_pkg::flags_t             s1_flags
);

  logic                   valid_r, valid_nxt;
  logic [SAMPLE_BITS-1:0] mag_r, mag_nxt;
  srd_pkg::flags_t        flags_r;
  logic                   take;

  // The most negative sample maps to 2^(SAMPLE_BITS-1), which still fits unsigned.
  assign mag_nxt   = in_sample[SAMPLE_BITS-1] ? (~in_sample + SAMPLE_BITS'(1)) : in_sample;
  assign in_tready = !valid_r || advance;
  assign take      = in_tvalid && in_tready;

  always_comb begin
    valid_nxt = valid_r;
    if (in_tready) begin
      valid_nxt = in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      mag_r   <= mag_nxt;
      flags_r <= in_flags;
    end
  end

  assign s1_valid = valid_r;
  assign s1_mag   = mag_r;
  assign s1_flags = flags_r;

endmodule

`default_nettype wire

// ===== rtl/srd_run_tracker.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Frame peak, silent-run state and the result register.
// Depends on srd_pkg for the settings and flag structs.

module srd_run_tracker #(
  parameter int FRAME_BITS  = srd_pkg::FRAME_BITS_DEF,
  parameter int SAMPLE_BITS = srd_pkg::SAMPLE_BITS_DEF
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  srd_pkg::cfg_t                    cfg,
  input  wire logic                        s1_valid,
  input  wire logic [SAMPLE_BITS-1:0]      s1_mag,
  input  srd_pkg::flags_t                  s1_flags,
  output logic                             advance,
  output logic                             out_tvalid,
  input  wire logic                        out_tready,
  output logic      [srd_pkg::OUT_W-1:0]   out_run_start,
  output logic      [srd_pkg::OUT_W-1:0]   out_run_length,
  output logic                             out_run_valid,
  output logic                             out_region_done
);

  localparam int CMP_W = (SAMPLE_BITS > srd_pkg::THR_W) ? SAMPLE_BITS : srd_pkg::THR_W;
  localparam int LEN_W = (FRAME_BITS > srd_pkg::MINF_W) ? FRAME_BITS : srd_pkg::MINF_W;

  logic [SAMPLE_BITS-1:0] peak_r, peak_nxt;
  logic                   in_run_r, in_run_nxt;
  logic [FRAME_BITS-1:0]  begin_r, begin_nxt;
  logic [FRAME_BITS-1:0]  fofs_r, fofs_nxt;

  logic                      out_valid_r, out_valid_nxt;
  logic [srd_pkg::OUT_W-1:0] out_start_r, out_start_nxt;
  logic [srd_pkg::OUT_W-1:0] out_len_r, out_len_nxt;
  logic                      out_rv_r, out_rv_nxt;
  logic                      out_done_r, out_done_nxt;

  logic                     fire;
  logic                     silent;
  logic                     run_open;
  logic                     run_shut;
  logic                     still_open;
  logic [LEN_W-1:0]         minf;
  logic [FRAME_BITS-1:0]    len_close;
  logic [FRAME_BITS-1:0]    len_end;
  logic [FRAME_BITS-1:0]    begin_eff;
  logic                     have_close;
  logic                     have_end;
  logic [FRAME_BITS-1:0]    res_begin;
  logic [FRAME_BITS-1:0]    res_len;
  logic                     res_have;

  assign advance = !out_valid_r || out_tready;
  assign fire    = s1_valid && advance;

  // The peak including this sample is silent only when both parts are.
  assign silent = (CMP_W'(peak_r) <= CMP_W'(cfg.threshold)) &&
                  (CMP_W'(s1_mag) <= CMP_W'(cfg.threshold));

  assign minf = (cfg.min_frames == '0) ? LEN_W'(1) : LEN_W'(cfg.min_frames);

  assign run_open   = silent && !in_run_r;
  assign run_shut   = !silent && in_run_r;
  assign still_open = run_open || (in_run_r && !run_shut);
  assign begin_eff  = run_open ? fofs_r : begin_r;

  assign len_close = fofs_r - begin_r;
  assign len_end   = run_open ? FRAME_BITS'(1) : (fofs_r + FRAME_BITS'(1) - begin_r);

  assign have_close = run_shut && (LEN_W'(len_close) >= minf) &&
                      (!cfg.trim_mode || (begin_r == '0));
  // A run still open at the last frame is reported in either mode.
  assign have_end   = s1_flags.region_end && still_open && (LEN_W'(len_end) >= minf);

  always_comb begin
    priority if (have_close) begin
      res_have  = 1'b1;
      res_begin = begin_r;
      res_len   = len_close;
    end else if (have_end) begin
      res_have  = 1'b1;
      res_begin = begin_eff;
      res_len   = len_end;
    end else begin
      res_have  = 1'b0;
      res_begin = '0;
      res_len   = '0;
    end
  end

  always_comb begin
    peak_nxt      = peak_r;
    in_run_nxt    = in_run_r;
    begin_nxt     = begin_r;
    fofs_nxt      = fofs_r;
    out_valid_nxt = out_valid_r;
    out_start_nxt = out_start_r;
    out_len_nxt   = out_len_r;
    out_rv_nxt    = out_rv_r;
    out_done_nxt  = out_done_r;
    if (advance) begin
      out_valid_nxt = 1'b0;
    end
    if (fire) begin
      if (!s1_flags.frame_end) begin
        if (s1_mag > peak_r) begin
          peak_nxt = s1_mag;
        end
      end else begin
        peak_nxt      = '0;
        out_start_nxt = res_have ? (cfg.region_start + srd_pkg::OUT_W'(res_begin)) : '0;
        out_len_nxt   = res_have ? srd_pkg::OUT_W'(res_len) : '0;
        out_rv_nxt    = res_have;
        out_done_nxt  = s1_flags.region_end;
        if (s1_flags.region_end) begin
          in_run_nxt    = 1'b0;
          begin_nxt     = '0;
          fofs_nxt      = '0;
          out_valid_nxt = 1'b1;
        end else begin
          in_run_nxt    = still_open;
          begin_nxt     = begin_eff;
          fofs_nxt      = fofs_r + FRAME_BITS'(1);
          out_valid_nxt = res_have;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      peak_r      <= '0;
      in_run_r    <= 1'b0;
      begin_r     <= '0;
      fofs_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      peak_r      <= peak_nxt;
      in_run_r    <= in_run_nxt;
      begin_r     <= begin_nxt;
      fofs_r      <= fofs_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_start_r <= out_start_nxt;
    out_len_r   <= out_len_nxt;
    out_rv_r    <= out_rv_nxt;
    out_done_r  <= out_done_nxt;
  end

  assign out_tvalid      = out_valid_r;
  assign out_run_start   = out_start_r;
  assign out_run_length  = out_len_r;
  assign out_run_valid   = out_rv_r;
  assign out_region_done = out_done_r;

  a_region_restart: assert property (@(posedge clk) disable iff (!rst_n)
    fire && s1_flags.frame_end && s1_flags.region_end
    |=> fofs_r == '0 && begin_r == '0 && !in_run_r && out_valid_r && out_done_r)
    else $error("region end did not restart run state or emit a closing word");

  a_peak_cleared: assert property (@(posedge clk) disable iff (!rst_n)
    fire && s1_flags.frame_end |=> peak_r == '0)
    else $error("frame peak not cleared at frame end");

  a_no_mid_frame_word: assert property (@(posedge clk) disable iff (!rst_n)
    fire && !s1_flags.frame_end |=> !out_valid_r)
    else $error("result word produced by a sample that does not end a frame");

  a_empty_word_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_rv_r |-> out_start_r == '0 && out_len_r == '0 && out_done_r)
    else $error("word without a run is not an empty closing marker");

endmodule

`default_nettype wire

// ===== rtl/silence_run_detector.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Top level of the silence run detector: stream ports, APB settings and two stages.
// Depends on srd_pkg, srd_cfg_regs, srd_mag_stage and srd_run_tracker.

// The block takes one channel-interleaved audio sample per clock unless the output
// stalls, and keeps the peak magnitude of the current frame; at the word that ends
// a frame it decides whether the frame is silent (peak at most threshold) and
// follows runs of silent frames. A run of at least min_frames frames comes out as
// one word with its absolute start frame (region_start plus the offset in the
// region) and its length; with trim_mode set only a run that starts at the region's
// first frame or is still open at its last frame is reported. The frame that ends a
// region always yields one closing word with region_done set, carrying the trailing
// run or an empty marker. Throughput is one sample per cycle unless the output
// stalls; a result passes the input register (magnitude), then the result register
// (run logic). A stalled output holds the pipeline, and at most one more sample is
// taken while a result waits. No clearing pass after reset.

module silence_run_detector #(
  parameter int FRAME_BITS  = srd_pkg::FRAME_BITS_DEF,
  parameter int SAMPLE_BITS = srd_pkg::SAMPLE_BITS_DEF
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  // in_tdata: [SAMPLE_BITS-1:0] sample, upper bits zero pad.
  input  wire logic [((SAMPLE_BITS+7)/8)*8-1:0] in_tdata,
  input  wire logic                             in_tvalid,
  output logic                                  in_tready,
  input  wire logic                             in_tlast,   // frame_end
  input  wire logic                             in_tuser,   // region_end
  // out_tdata: [31:0] run_start, [63:32] run_length.
  output logic      [srd_pkg::OUT_TDATA_W-1:0]  out_tdata,
  output logic                                  out_tvalid,
  input  wire logic                             out_tready,
  output logic                                  out_tlast,  // region_done
  output logic                                  out_tuser,  // run_valid
  input  wire logic                             cfg_psel,
  input  wire logic                             cfg_penable,
  input  wire logic                             cfg_pwrite,
  input  wire logic [srd_pkg::ADDR_W-1:0]       cfg_paddr,
  input  wire logic [srd_pkg::REG_W-1:0]        cfg_pwdata,
  output logic      [srd_pkg::REG_W-1:0]        cfg_prdata,
  output logic                                  cfg_pready
);

  srd_pkg::cfg_t             cfg;
  srd_pkg::flags_t           in_flags;
  srd_pkg::flags_t           s1_flags;
  logic                      s1_valid;
  logic [SAMPLE_BITS-1:0]    s1_mag;
  logic                      advance;
  logic [srd_pkg::OUT_W-1:0] run_start;
  logic [srd_pkg::OUT_W-1:0] run_length;

  assign in_flags.frame_end  = in_tlast;
  assign in_flags.region_end = in_tuser;

  srd_cfg_regs u_cfg (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready),
    .cfg         (cfg)
  );

  srd_mag_stage #(
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_mag (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_sample (in_tdata[SAMPLE_BITS-1:0]),
    .in_flags  (in_flags),
    .advance   (advance),
    .s1_valid  (s1_valid),
    .s1_mag    (s1_mag),
    .s1_flags  (s1_flags)
  );

  srd_run_tracker #(
    .FRAME_BITS  (FRAME_BITS),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_track (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg             (cfg),
    .s1_valid        (s1_valid),
    .s1_mag          (s1_mag),
    .s1_flags        (s1_flags),
    .advance         (advance),
    .out_tvalid      (out_tvalid),
    .out_tready      (out_tready),
    .out_run_start   (run_start),
    .out_run_length  (run_length),
    .out_run_valid   (out_tuser),
    .out_region_done (out_tlast)
  );

  assign out_tdata = {run_length, run_start};

endmodule

`default_nettype wire

// ===== tb/sv/silence_run_detector_tb.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for silence_run_detector: a directed table, then random
// frames and regions under three idle patterns, checked against a built-in predictor.
// Depends on srd_pkg and the RTL under rtl/.

module silence_run_detector_tb;

  localparam int SAMPLE_W     = srd_pkg::SAMPLE_BITS_DEF;
  localparam int IN_W         = ((SAMPLE_W + 7) / 8) * 8;
  localparam int CYCLE_LIMIT  = 200000;
  localparam int SETTLE_CYCLES = 8;
  localparam int TAIL_CYCLES  = 10;
  localparam int HOLD_CYCLES  = 400;
  localparam int PHASE_ITEMS  = 32;
  localparam logic [24:0] MAG_MAX = 25'h0800000;

  typedef struct {
    logic [31:0] start;
    logic [31:0] length;
    bit          valid;
    bit          done;
  } run_word_t;

  typedef enum bit {ROW_ITEM, ROW_CFG} row_kind_t;

  typedef struct {
    row_kind_t          kind;
    srd_pkg::reg_idx_t  ridx;
    logic [31:0]        value;
    bit                 fe;
    bit                 re;
    bit                 typed;
    run_word_t          exp;
  } stim_row_t;

  logic                            clk = 1'b0;
  logic                            rst_n = 1'b0;
  logic [IN_W-1:0]                 in_tdata = '0;   // [23:0] sample
  logic                            in_tvalid = 1'b0;
  logic                            in_tready;
  logic                            in_tlast = 1'b0; // frame_end
  logic                            in_tuser = 1'b0; // region_end
  logic [srd_pkg::OUT_TDATA_W-1:0] out_tdata;       // [31:0] run_start, [63:32] run_length
  logic                            out_tvalid;
  logic                            out_tready = 1'b0;
  logic                            out_tlast;       // region_done
  logic                            out_tuser;       // run_valid
  logic                            cfg_psel = 1'b0;
  logic                            cfg_penable = 1'b0;
  logic                            cfg_pwrite = 1'b0;
  logic [srd_pkg::ADDR_W-1:0]      cfg_paddr = '0;
  logic [srd_pkg::REG_W-1:0]       cfg_pwdata = '0;
  logic [srd_pkg::REG_W-1:0]       cfg_prdata;
  logic                            cfg_pready;

  always #5 clk = ~clk;

  silence_run_detector u_top (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tdata    (in_tdata),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tlast    (in_tlast),
    .in_tuser    (in_tuser),
    .out_tdata   (out_tdata),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tlast   (out_tlast),
    .out_tuser   (out_tuser),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  // Register copies and run-tracking state of the predictor.
  logic [23:0] sh_threshold    = '0;
  logic [23:0] sh_min_frames   = 24'd1;
  bit          sh_trim         = 1'b0;
  logic [31:0] sh_region_start = '0;
  logic [23:0] cur_peak  = '0;
  bit          run_open  = 1'b0;
  logic [31:0] run_first = '0;
  logic [31:0] frame_no  = '0;

  run_word_t expected_runs[$];
  stim_row_t directed_rows[$];

  int n_fail = 0;
  int n_cycles = 0;
  int n_items = 0;
  int n_results = 0;
  int n_runs = 0;
  int n_regions = 0;
  int n_writes = 0;
  int tx_idle_pct = 0;
  int rx_idle_pct = 0;
  int hold_reqs = 0;
  int hold_served = 0;
  int stall_left = 0;

  // Folds one sample into the frame peak; returns 1 when the word yields a result.
  function automatic bit detect_step(input logic [23:0] smp, input bit fe, input bit re,
                                     output run_word_t w);
    logic [24:0] mag;
    logic [31:0] len;
    logic [31:0] minf;
    bit          silent;
    bit          have;
    logic [31:0] rb;
    logic [31:0] rl;
    w = '{default: '0};
    have = 1'b0;
    rb = '0;
    rl = '0;
    mag = smp[23] ? (25'h1000000 - {1'b0, smp}) : {1'b0, smp};
    minf = (sh_min_frames == '0) ? 32'd1 : {8'd0, sh_min_frames};
    if (mag[23:0] > cur_peak) cur_peak = mag[23:0];
    if (!fe) return 1'b0;
    silent = cur_peak <= sh_threshold;
    cur_peak = '0;
    if (silent && !run_open) begin
      run_open = 1'b1;
      run_first = frame_no;
    end else if (!silent && run_open) begin
      len = frame_no - run_first;
      if (len >= minf && (!sh_trim || run_first == '0)) begin
        have = 1'b1;
        rb = run_first;
        rl = len;
      end
      run_open = 1'b0;
    end
    if (!re) begin
      frame_no = frame_no + 32'd1;
      if (!have) return 1'b0;
    end else begin
      // A run still open at the last frame is reported together with the close.
      if (run_open) begin
        len = frame_no + 32'd1 - run_first;
        if (len >= minf) begin
          have = 1'b1;
          rb = run_first;
          rl = len;
        end
      end
      run_open = 1'b0;
      run_first = '0;
      frame_no = '0;
    end
    w.valid = have;
    w.done = re;
    w.start = have ? sh_region_start + rb : '0;
    w.length = have ? rl : '0;
    return 1'b1;
  endfunction

  function automatic stim_row_t item_row(input logic [23:0] smp, input bit fe, input bit re);
    stim_row_t r;
    r.kind = ROW_ITEM;
    r.ridx = srd_pkg::REG_THRESHOLD;
    r.value = {8'd0, smp};
    r.fe = fe;
    r.re = re;
    r.typed = 1'b0;
    r.exp = '{default: '0};
    return r;
  endfunction

  function automatic void add_item(input logic [23:0] smp, input bit fe, input bit re);
    directed_rows.insert(directed_rows.size(), item_row(smp, fe, re));
  endfunction

  function automatic void add_checked(input logic [23:0] smp, input bit fe, input bit re,
                                      input logic [31:0] start, input logic [31:0] len,
                                      input bit valid, input bit done);
    stim_row_t r;
    r = item_row(smp, fe, re);
    r.typed = 1'b1;
    r.exp = '{start, len, valid, done};
    directed_rows.insert(directed_rows.size(), r);
  endfunction

  function automatic void add_cfg(input srd_pkg::reg_idx_t ridx, input logic [31:0] value);
    stim_row_t r;
    r = item_row('0, 1'b0, 1'b0);
    r.kind = ROW_CFG;
    r.ridx = ridx;
    r.value = value;
    directed_rows.insert(directed_rows.size(), r);
  endfunction

  // Picks a sample whose magnitude is above or at most the threshold, often right at the edge.
  function automatic logic [23:0] pick_sample(input bit loud);
    logic [24:0] mag;
    bit          neg;
    if (loud && {1'b0, sh_threshold} < MAG_MAX) begin
      if ($urandom_range(2, 0) == 0) mag = {1'b0, sh_threshold} + 25'd1;
      else mag = 25'($urandom_range(32'(MAG_MAX), 32'(sh_threshold) + 32'd1));
    end else begin
      if ($urandom_range(2, 0) == 0) mag = {1'b0, sh_threshold};
      else mag = 25'($urandom_range(32'(sh_threshold), 0));
    end
    neg = (mag == MAG_MAX) ? 1'b1 : 1'($urandom_range(1, 0));
    return neg ? 24'(-mag) : mag[23:0];
  endfunction

  task automatic check_field(input string name, input logic [31:0] exp, input logic [31:0] act);
    if (act !== exp) begin
      $error("%s: expected %0h, got %0h", name, exp, act);
      n_fail++;
    end
  endtask

  task automatic push_sample(input stim_row_t r);
    run_word_t w;
    bit        has;
    @(negedge clk);
    while ($urandom_range(99, 0) < tx_idle_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= IN_W'(r.value[23:0]);
    in_tlast <= r.fe;
    in_tuser <= r.re;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    n_items++;
    has = detect_step(r.value[23:0], r.fe, r.re, w);
    if (r.typed) expected_runs.insert(expected_runs.size(), r.exp);
    else if (has) expected_runs.insert(expected_runs.size(), w);
  endtask

  // Lets every expected word drain, then a few cycles for words that produce none.
  task automatic settle();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (expected_runs.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input srd_pkg::reg_idx_t ridx, input logic [31:0] value);
    logic [31:0] rd_exp;
    @(negedge clk);
    cfg_psel <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= {ridx, 2'b00};
    cfg_pwdata <= value;
    @(negedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    case (ridx)
      srd_pkg::REG_THRESHOLD: begin
        sh_threshold = value[23:0];
        rd_exp = {8'd0, sh_threshold};
      end
      srd_pkg::REG_MIN_FRAMES: begin
        sh_min_frames = value[23:0];
        rd_exp = {8'd0, sh_min_frames};
      end
      srd_pkg::REG_TRIM_MODE: begin
        sh_trim = value[0];
        rd_exp = {31'd0, sh_trim};
      end
      default: begin
        sh_region_start = value;
        rd_exp = value;
      end
    endcase
    n_writes++;
    @(negedge clk);
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    @(negedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    check_field({"readback ", ridx.name()}, rd_exp, cfg_prdata);
    @(negedge clk);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
  endtask

  task automatic set_config(input logic [23:0] thr, input logic [23:0] minf, input bit trim,
                            input logic [31:0] rs);
    write_reg(srd_pkg::REG_THRESHOLD, {8'd0, thr});
    write_reg(srd_pkg::REG_MIN_FRAMES, {8'd0, minf});
    write_reg(srd_pkg::REG_TRIM_MODE, {31'd0, trim});
    write_reg(srd_pkg::REG_REGION_START, rs);
  endtask

  // Whole regions of frames with runs of silent and loud frames, plus some noise words.
  task automatic random_traffic(input int n_target);
    int          sent;
    int          frames;
    int          nch;
    int          loud_ch;
    bit          loud;
    bit          last_ch;
    bit          re;
    logic [23:0] smp;
    sent = 0;
    loud = 1'b0;
    while (sent < n_target) begin
      frames = ($urandom_range(9, 0) == 0) ? 1 : $urandom_range(12, 2);
      for (int f = 0; f < frames; f++) begin
        if ($urandom_range(99, 0) < 35) loud = !loud;
        if ($urandom_range(99, 0) < 8) begin
          push_sample(item_row(24'($urandom()), 1'($urandom_range(1, 0)),
                               1'($urandom_range(1, 0))));
          sent++;
        end
        nch = $urandom_range(4, 1);
        loud_ch = $urandom_range(nch - 1, 0);
        for (int c = 0; c < nch; c++) begin
          last_ch = (c == nch - 1);
          smp = pick_sample(loud && (c == loud_ch || $urandom_range(1, 0) == 1));
          // A region end flag away from a frame end must be ignored.
          re = last_ch ? (f == frames - 1) : ($urandom_range(9, 0) == 0);
          push_sample(item_row(smp, last_ch, re));
          sent++;
        end
      end
    end
  endtask

  always @(negedge clk) begin
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_tready <= 1'b0;
    end else if (hold_served != hold_reqs) begin
      hold_served <= hold_reqs;
      stall_left <= HOLD_CYCLES;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99, 0) >= rx_idle_pct);
    end
  end

  always @(posedge clk) begin : result_monitor
    run_word_t w;
    if (rst_n && out_tvalid && out_tready) begin
      n_results++;
      if (out_tuser) n_runs++;
      if (out_tlast) n_regions++;
      if (expected_runs.size() == 0) begin
        $error("result word with none expected: start %0h length %0h valid %0b done %0b",
               out_tdata[31:0], out_tdata[63:32], out_tuser, out_tlast);
        n_fail++;
      end else begin
        w = expected_runs.pop_front();
        check_field("run_start", w.start, out_tdata[31:0]);
        check_field("run_length", w.length, out_tdata[63:32]);
        check_field("run_valid", {31'd0, w.valid}, {31'd0, out_tuser});
        check_field("region_done", {31'd0, w.done}, {31'd0, out_tlast});
      end
    end
  end

  always @(posedge clk) begin
    n_cycles++;
    if (n_cycles > CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  initial begin
    // Reset settings: threshold 0, so only all-zero frames are silent.
    add_item(24'h000000, 1'b1, 1'b0);
    add_checked(24'h7FFFFF, 1'b1, 1'b0, 32'd0, 32'd1, 1'b1, 1'b0);
    add_checked(24'h800000, 1'b1, 1'b1, 32'd0, 32'd0, 1'b0, 1'b1);
    add_item(24'h000000, 1'b0, 1'b1);
    add_checked(24'h000000, 1'b1, 1'b1, 32'd0, 32'd1, 1'b1, 1'b1);
    // Full-scale threshold: even the most negative sample is silent.
    add_cfg(srd_pkg::REG_THRESHOLD, 32'h0080_0000);
    add_item(24'h800000, 1'b0, 1'b0);
    add_checked(24'h7FFFFF, 1'b1, 1'b1, 32'd0, 32'd1, 1'b1, 1'b1);
    // Zero min_frames acts as one; run_start reaches the top of its 32-bit range.
    add_cfg(srd_pkg::REG_THRESHOLD, 32'd100);
    add_cfg(srd_pkg::REG_MIN_FRAMES, 32'd0);
    add_cfg(srd_pkg::REG_REGION_START, 32'hFFFF_FFFF);
    add_item(24'd100, 1'b1, 1'b0);
    add_checked(24'(-101), 1'b1, 1'b0, 32'hFFFF_FFFF, 32'd1, 1'b1, 1'b0);
    add_item(24'd50, 1'b0, 1'b0);
    add_item(24'(-100), 1'b1, 1'b0);
    add_item(24'd0, 1'b1, 1'b0);
    // Region start changed mid-region; a loud last frame closes the run in the done word.
    add_cfg(srd_pkg::REG_REGION_START, 32'd5);
    add_checked(24'd200, 1'b1, 1'b1, 32'd7, 32'd2, 1'b1, 1'b1);
    // Trim mode: a short run and a run in the middle are dropped, the trailing one kept.
    add_cfg(srd_pkg::REG_MIN_FRAMES, 32'd3);
    add_cfg(srd_pkg::REG_TRIM_MODE, 32'd1);
    add_cfg(srd_pkg::REG_REGION_START, 32'd0);
    add_item(24'd0, 1'b1, 1'b0);
    add_item(24'd0, 1'b1, 1'b0);
    add_item(24'd1000, 1'b1, 1'b0);
    add_item(24'd0, 1'b1, 1'b0);
    add_item(24'd0, 1'b1, 1'b0);
    add_item(24'd0, 1'b1, 1'b0);
    add_item(24'd1000, 1'b1, 1'b0);
    add_item(24'd0, 1'b1, 1'b0);
    add_item(24'd0, 1'b1, 1'b0);
    add_checked(24'd0, 1'b1, 1'b1, 32'd7, 32'd3, 1'b1, 1'b1);
    // A run that both starts the region and reaches its end is reported once.
    add_item(24'd0, 1'b1, 1'b0);
    add_item(24'd0, 1'b1, 1'b0);
    add_checked(24'd0, 1'b1, 1'b1, 32'd0, 32'd3, 1'b1, 1'b1);

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    foreach (directed_rows[i]) begin
      if (directed_rows[i].kind == ROW_CFG) begin
        settle();
        write_reg(directed_rows[i].ridx, directed_rows[i].value);
      end else begin
        push_sample(directed_rows[i]);
      end
    end

    for (int p = 0; p < 9; p++) begin
      settle();
      case (p)
        0: set_config(24'h001000, 24'd1, 1'b0, $urandom());
        1: set_config(24'h000400, 24'd3, 1'b1, $urandom());
        2: set_config(24'h000000, 24'd2, 1'b0, 32'hFFFF_FFFF);
        3: set_config(24'h7FFFFF, 24'd1, 1'b1, $urandom());
        4: set_config(24'($urandom_range(32'h0080_0000, 0)), 24'd0, 1'b0, 32'd0);
        5: set_config(24'h800000, 24'hFFFFFF, 1'b0, $urandom());
        6: set_config(24'h002000, 24'd2, 1'b0, $urandom());
        7: set_config(24'($urandom_range(32'h0080_0000, 0)), 24'($urandom_range(6, 1)), 1'b1,
                      $urandom());
        default: set_config(24'h000100, 24'd1, 1'b0, 32'hFFFF_FFF8);
      endcase
      tx_idle_pct = (p < 3) ? 6 : (p < 6) ? 83 : 0;
      rx_idle_pct = (p < 3) ? 83 : (p < 6) ? 6 : 0;
      if (p == 1) begin
        random_traffic(PHASE_ITEMS / 2);
        settle();
      end
      if (p == 6) begin
        // One-frame regions each yield a word, so the stalled output backs up the input.
        hold_reqs++;
        repeat (40) push_sample(item_row(pick_sample(1'($urandom_range(1, 0))), 1'b1, 1'b1));
      end
      random_traffic(PHASE_ITEMS);
    end

    @(negedge clk);
    in_tvalid <= 1'b0;
    while (expected_runs.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("Sent %0d sample words under %0d register writes and three idle patterns.",
             n_items, n_writes);
    $display("Checked %0d result words: %0d silent runs, %0d region closes, %0d cycles.",
             n_results, n_runs, n_regions, n_cycles);
    if (n_fail == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
